/* sv/sorted_book_best_entry_lookup_assert.svh */
// Assertion macros for the sorted book best-entry lookup.
// Each macro clocks on clk_i and is disabled while rst_ni is low.
`ifndef SORTED_BOOK_BEST_ENTRY_LOOKUP_ASSERT_SVH
`define SORTED_BOOK_BEST_ENTRY_LOOKUP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SBBEL_ASSERT_HOLDS(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SBBEL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/sbbel_pkg.sv */
// Shared types, codes and move decode helpers for the sorted book lookup.
// No dependencies; used by sbbel_ram and the top level.
package sbbel_pkg;

  // One stored book entry.
  typedef struct packed {
    logic [63:0] key;
    logic [15:0] move;
    logic [15:0] weight;
    logic [31:0] learn;
  } entry_t;

  // Operation codes of an input transaction.
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // Register index of entry_count, taken from paddr bit 2.
  localparam logic REG_ENTRY_COUNT = 1'b0;

  // Move word layout.
  localparam int unsigned    FROM_SHIFT  = 6;
  localparam int unsigned    PROMO_SHIFT = 12;
  localparam logic [15:0]    SQUARE_MASK = 16'h003f;
  localparam logic [15:0]    PROMO_MASK  = 16'h0007;

  function automatic logic [5:0] dst_sq(logic [15:0] mv);
    return 6'(mv & SQUARE_MASK);
  endfunction

  function automatic logic [5:0] src_sq(logic [15:0] mv);
    return 6'((mv >> FROM_SHIFT) & SQUARE_MASK);
  endfunction

  // Promotion piece is the 3-bit field plus one, or zero when the field is zero.
  function automatic logic [3:0] promotion(logic [15:0] mv);
    logic [2:0] p;
    p = 3'((mv >> PROMO_SHIFT) & PROMO_MASK);
    return (p == 3'd0) ? 4'd0 : ({1'b0, p} + 4'd1);
  endfunction

endpackage

/* sv/sbbel_ram.sv */
// Single-port entry memory with a registered read port.
// Depends on sbbel_pkg for the entry type.
module sbbel_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AW-1:0]       addr_i,
  input  sbbel_pkg::entry_t   wdata_i,
  output sbbel_pkg::entry_t   rdata_o
);

  sbbel_pkg::entry_t mem [DEPTH];
  sbbel_pkg::entry_t rdata_q;

  // One access per cycle; the read data is valid the cycle after the address.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/sorted_book_best_entry_lookup.sv */
// Sorted book best-entry lookup: sequencer, search datapath and output register.
// Depends on sbbel_pkg, sbbel_ram and sorted_book_best_entry_lookup_assert.svh.
//
// Usage:
//   The input channel (in_valid_i / in_ready_o) carries write and lookup
//   transactions. A write stores one entry at in_index_i; it produces no
//   result. A lookup runs a leftmost binary search for in_key_i
//   over the first entry_count entries, then scans the run of equal keys and
//   returns the first heaviest entry that is not below in_minimum_weight_i.
//   Each lookup produces exactly one result transaction on the output channel
//   (out_valid_o / out_ready_i); out_found_o is low and all fields zero when
//   nothing qualifies.
//   A lookup runs in steps: a start step, the search steps with a read of
//   the first candidate, a scan step for each equal-key entry, and a step
//   that loads the output register. The single memory port, read once per
//   cycle, paces these steps.
//   The block takes one transaction at a time. A finished result sits in the
//   output register while the next transaction is accepted; if the receiver
//   stalls, a second lookup waits in its last step until the register frees.
//   The user must write entry_count over the APB port only while the block is idle; the block does not enforce this.
//   Reset clears the control state and entry_count; table contents are not
//   cleared and need no clearing pass.
`include "sorted_book_best_entry_lookup_assert.svh"

module sorted_book_best_entry_lookup #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        in_operation_i,
  input  logic [9:0]  in_index_i,
  input  logic [63:0] in_key_i,
  input  logic [15:0] in_move_i,
  input  logic [15:0] in_weight_i,
  input  logic [31:0] in_learn_i,
  input  logic [15:0] in_minimum_weight_i,
  // Output channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        out_found_o,
  output logic [9:0]  out_entry_index_o,
  output logic [15:0] out_move_word_o,
  output logic [15:0] out_entry_weight_o,
  output logic [31:0] out_entry_learn_o,
  output logic [5:0]  out_src_sq_o,
  output logic [5:0]  out_dst_sq_o,
  output logic [3:0]  out_promotion_o
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned NW = AW + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SCAN,
    ST_DONE
  } state_e;

  state_e            state_q;
  logic [10:0]       count_q;
  logic [63:0]       key_q;
  logic [15:0]       minw_q;
  logic [NW-1:0]     n_q;
  logic [NW-1:0]     lo_q;
  logic [NW-1:0]     hi_q;
  logic [NW-1:0]     mid_q;
  logic [NW-1:0]     idx_q;
  logic              have_q;
  logic [NW-1:0]     best_idx_q;
  logic [15:0]       best_move_q;
  logic [15:0]       best_weight_q;
  logic [31:0]       best_learn_q;
  logic              out_valid_q;
  logic              out_found_q;
  logic [9:0]        out_index_q;
  logic [15:0]       out_move_q;
  logic [15:0]       out_weight_q;
  logic [31:0]       out_learn_q;

  logic              cfg_write;
  logic              in_fire;
  logic              lookup_fire;
  logic [NW-1:0]     n_in;
  logic              key_lt;
  logic [NW-1:0]     lo_nxt;
  logic [NW-1:0]     hi_nxt;
  logic [NW:0]       mid_sum;
  logic [NW-1:0]     mid_nxt;
  logic [NW-1:0]     scan_nxt;
  logic              take_entry;
  logic              out_free;
  logic              out_load;
  logic              probe_ok;
  logic              ram_we;
  logic [AW-1:0]     ram_addr;
  sbbel_pkg::entry_t ram_wdata;
  sbbel_pkg::entry_t ram_rdata;

  // Configuration register: entry_count at byte address 0.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready &&
                     (paddr[2] == sbbel_pkg::REG_ENTRY_COUNT);
  assign prdata    = (paddr[2] == sbbel_pkg::REG_ENTRY_COUNT) ? {21'd0, count_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_write) begin
      count_q <= pwdata[10:0];
    end
  end

  // Number of searchable entries, capped at the table depth.
  assign n_in = (32'(count_q) > 32'(TABLE_DEPTH)) ? NW'(TABLE_DEPTH) : NW'(count_q);

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign lookup_fire = in_fire && (in_operation_i == sbbel_pkg::OP_LOOKUP);

  // Shared compare-and-halve step of the binary search.
  assign key_lt  = (ram_rdata.key < key_q);
  assign lo_nxt  = key_lt ? (mid_q + 1'b1) : lo_q;
  assign hi_nxt  = key_lt ? hi_q : mid_q;
  assign mid_sum = {1'b0, lo_nxt} + {1'b0, hi_nxt};
  assign mid_nxt = NW'(mid_sum >> 1);

  // Scan step over the run of equal keys.
  assign scan_nxt   = idx_q + 1'b1;
  assign take_entry = (ram_rdata.weight >= minw_q) &&
                      (!have_q || (ram_rdata.weight > best_weight_q));

  assign out_free = !out_valid_q || out_ready_i;
  assign out_load = (state_q == ST_DONE) && out_free;

  // Memory port: writes from the input channel, reads from the sequencer.
  assign ram_we = in_fire && (in_operation_i == sbbel_pkg::OP_WRITE) &&
                  (32'(in_index_i) < 32'(TABLE_DEPTH));
  assign ram_wdata = '{key: in_key_i, move: in_move_i,
                       weight: in_weight_i, learn: in_learn_i};

  always_comb begin
    unique case (state_q)
      ST_IDLE: begin
        ram_addr = (in_operation_i == sbbel_pkg::OP_WRITE) ? AW'(in_index_i)
                                                           : AW'(n_in >> 1);
      end
      ST_SEARCH: begin
        ram_addr = (lo_nxt < hi_nxt) ? AW'(mid_nxt) : AW'(lo_nxt);
      end
      ST_SCAN: begin
        ram_addr = AW'(scan_nxt);
      end
      default: begin
        ram_addr = '0;
      end
    endcase
  end

  sbbel_ram #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // Sequencer with the registered result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      key_q         <= '0;
      minw_q        <= '0;
      n_q           <= '0;
      lo_q          <= '0;
      hi_q          <= '0;
      mid_q         <= '0;
      idx_q         <= '0;
      have_q        <= 1'b0;
      best_idx_q    <= '0;
      best_move_q   <= '0;
      best_weight_q <= '0;
      best_learn_q  <= '0;
      out_valid_q   <= 1'b0;
      out_found_q   <= 1'b0;
      out_index_q   <= '0;
      out_move_q    <= '0;
      out_weight_q  <= '0;
      out_learn_q   <= '0;
    end else begin
      // The output register fills from the last step and drains on acceptance.
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (lookup_fire) begin
            key_q         <= in_key_i;
            minw_q        <= in_minimum_weight_i;
            n_q           <= n_in;
            lo_q          <= '0;
            hi_q          <= n_in;
            mid_q         <= n_in >> 1;
            have_q        <= 1'b0;
            best_idx_q    <= '0;
            best_move_q   <= '0;
            best_weight_q <= '0;
            best_learn_q  <= '0;
            state_q       <= (n_in == '0) ? ST_DONE : ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          lo_q <= lo_nxt;
          hi_q <= hi_nxt;
          if (lo_nxt < hi_nxt) begin
            mid_q <= mid_nxt;
          end else if (lo_nxt < n_q) begin
            idx_q   <= lo_nxt;
            state_q <= ST_SCAN;
          end else begin
            state_q <= ST_DONE;
          end
        end
        ST_SCAN: begin
          if (ram_rdata.key != key_q) begin
            state_q <= ST_DONE;
          end else begin
            if (take_entry) begin
              have_q        <= 1'b1;
              best_idx_q    <= idx_q;
              best_move_q   <= ram_rdata.move;
              best_weight_q <= ram_rdata.weight;
              best_learn_q  <= ram_rdata.learn;
            end
            if (scan_nxt < n_q) begin
              idx_q <= scan_nxt;
            end else begin
              state_q <= ST_DONE;
            end
          end
        end
        ST_DONE: begin
          // Best registers stay zero when nothing qualified.
          if (out_free) begin
            out_found_q  <= have_q;
            out_index_q  <= 10'(best_idx_q);
            out_move_q   <= best_move_q;
            out_weight_q <= best_weight_q;
            out_learn_q  <= best_learn_q;
            state_q      <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Result fields, with the move word decoded.
  assign out_valid_o        = out_valid_q;
  assign out_found_o        = out_found_q;
  assign out_entry_index_o  = out_index_q;
  assign out_move_word_o    = out_move_q;
  assign out_entry_weight_o = out_weight_q;
  assign out_entry_learn_o  = out_learn_q;
  assign out_src_sq_o       = sbbel_pkg::src_sq(out_move_q);
  assign out_dst_sq_o       = sbbel_pkg::dst_sq(out_move_q);
  assign out_promotion_o    = sbbel_pkg::promotion(out_move_q);

  assign probe_ok = (mid_q >= lo_q) && (mid_q < hi_q);

  // The probe address always lies inside the current search window.
  `SBBEL_ASSERT_HOLDS(a_mid_in_window, state_q == ST_SEARCH, probe_ok, "probe outside window")
  // The scan never reads past the searchable entries.
  `SBBEL_ASSERT_HOLDS(a_scan_in_range, state_q == ST_SCAN, idx_q < n_q, "scan past entry count")
  // An accepted lookup keeps the input channel closed in the next cycle.
  `SBBEL_ASSERT_NEXT(a_lookup_busy, lookup_fire, !in_ready_o, "lookup left the input open")

endmodule
